// ===== rtl/core/cconv_pkg.sv =====
// Shared types and constants for the centered 1-D convolution block.
// Used by cconv_cell, cconv_adder and centered_1d_convolution; no dependencies.
package cconv_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int SUM_BITS       = 35;
    localparam int TAP_BITS       = 3;
    localparam int COEF_REGS      = 7;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Register map
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_COUNT  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_FIRST = 3'd1;

    localparam logic [TAP_BITS-1:0] TAP_COUNT_RESET = 3'd5;

    // Input transaction
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } sample_item_t;

    // Output transaction
    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic                       last_result;
    } result_item_t;

    // Per-cycle controls for the cell chain
    typedef struct packed {
        logic shift;
        logic clear;
        logic load;
    } cell_ctrl_t;

    // Load enables for the adder stages
    typedef struct packed {
        logic load_grp;
        logic load_out;
    } sum_ctrl_t;

endpackage

// ===== rtl/core/cconv_cell.sv =====
// One cell of the convolution chain: holds one window sample and its product.
// Depends on cconv_pkg.
module cconv_cell
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  cconv_pkg::cell_ctrl_t                      ctrl,
    input  logic signed [cconv_pkg::SAMPLE_BITS-1:0]   din,
    input  logic signed [cconv_pkg::COEF_BITS-1:0]     coef,
    output logic signed [cconv_pkg::SAMPLE_BITS-1:0]   sample_q,
    output logic signed [cconv_pkg::PROD_BITS-1:0]     prod_q
);

    logic signed [cconv_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic signed [cconv_pkg::SAMPLE_BITS-1:0] sample_next;
    logic signed [cconv_pkg::PROD_BITS-1:0]   prod_reg;
    logic signed [cconv_pkg::PROD_BITS-1:0]   prod_next;

    // Shift takes the neighbor's sample; a clear alone empties the cell
    always_comb
    begin
        sample_next = sample_reg;
        if (ctrl.shift)
        begin
            sample_next = din;
        end
        else if (ctrl.clear)
        begin
            sample_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    // Tap product, registered
    assign prod_next = sample_reg * coef;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign sample_q = sample_reg;
    assign prod_q   = prod_reg;

endmodule

// ===== rtl/core/cconv_adder.sv =====
// Two-stage registered adder tree: groups of four products, then the total.
// Depends on cconv_pkg.
module cconv_adder
#(
    parameter int MAX_TAPS = 7
)
(
    input  logic                                      clk,
    input  cconv_pkg::sum_ctrl_t                      ctrl,
    input  logic signed [cconv_pkg::PROD_BITS-1:0]    prod [MAX_TAPS],
    output logic signed [cconv_pkg::SUM_BITS-1:0]     sum
);

    localparam int GROUPS = (MAX_TAPS + 3) / 4;
    localparam int ACC_W  = cconv_pkg::PROD_BITS + $clog2(MAX_TAPS + 1);

    logic signed [ACC_W-1:0]              grp_reg  [GROUPS];
    logic signed [ACC_W-1:0]              grp_next [GROUPS];
    logic signed [ACC_W-1:0]              total_next;
    logic signed [cconv_pkg::SUM_BITS-1:0] sum_reg;

    // First level: up to four products per group
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int i = 0; i < 4; i++)
            begin
                if (g * 4 + i < MAX_TAPS)
                begin
                    grp_next[g] = grp_next[g] + ACC_W'(prod[g * 4 + i]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_grp)
        begin
            grp_reg <= grp_next;
        end
    end

    // Second level: total of the groups
    always_comb
    begin
        total_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            total_next = total_next + grp_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            sum_reg <= cconv_pkg::SUM_BITS'(total_next);
        end
    end

    assign sum = sum_reg;

endmodule

// ===== rtl/core/centered_1d_convolution.sv =====
// Top level of the centered 1-D convolution: cell chain, flush control, adder.
// Depends on cconv_pkg, cconv_cell and cconv_adder.
//
// Takes one sample and returns one result per clock unless stalled, once the
// window has seen the look-ahead (tap_count - 1 - tap_count/2 samples, at
// most 3). A result passes the window cell, each cell's product register, the
// group-sum register and the output register after the sample that completes
// it. The sample marked last makes the chain shift in as many zeros as the
// look-ahead, one per cycle unless stalled, with sample_ready low meanwhile;
// the pending results come out in order, the final one marked with
// last_result, and the window and count are cleared for the next vector. The
// output register and the pipeline stages soak up stalls: an empty stage lets
// new samples in while a result waits on result_ready. No clearing pass follows
// reset. Configuration must be written only while idle; nothing enforces it.
module centered_1d_convolution
#(
    parameter int MAX_TAPS = 7
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          sample_valid,
    output logic                                          sample_ready,
    input  cconv_pkg::sample_item_t                       sample_data,
    output logic                                          result_valid,
    input  logic                                          result_ready,
    output cconv_pkg::result_item_t                       result_data,
    input  logic                                          cfg_we,
    input  logic [cconv_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
    input  logic [cconv_pkg::CFG_DATA_BITS-1:0]           cfg_data
);

    localparam int TAPS_USED = (MAX_TAPS < cconv_pkg::COEF_REGS) ? MAX_TAPS
                                                                 : cconv_pkg::COEF_REGS;
    localparam int LOOK_MAX  = (TAPS_USED - 1) - TAPS_USED / 2;
    localparam int CNT_W     = (LOOK_MAX < 2) ? 1 : $clog2(LOOK_MAX + 1);

    // Configuration
    logic [cconv_pkg::TAP_BITS-1:0]           tap_count_reg;
    logic signed [cconv_pkg::COEF_BITS-1:0]   coef_reg [cconv_pkg::COEF_REGS];
    logic [cconv_pkg::CFG_INDEX_BITS-1:0]     coef_addr;

    // Derived tap geometry
    logic [cconv_pkg::TAP_BITS-1:0] taps_c;
    logic [cconv_pkg::TAP_BITS-1:0] look_full;
    logic [CNT_W-1:0]               look;
    logic [CNT_W-1:0]               seen_eff;

    // Vector and flush state
    logic [CNT_W-1:0] seen_reg,  seen_next;
    logic             flushing_reg, flushing_next;
    logic [CNT_W-1:0] left_reg,  left_next;
    logic [CNT_W-1:0] fseen_reg, fseen_next;
    logic [CNT_W-1:0] left_dec;

    // Pipeline stage flags: A window, B products, C groups, D output
    logic a_valid_reg, a_valid_next, a_last_reg, a_last_next;
    logic b_valid_reg, b_last_reg;
    logic c_valid_reg, c_last_reg;
    logic d_valid_reg, d_last_reg;

    // Handshake and chain control
    logic adv_b, adv_c, adv_d, shift_ok;
    logic take_sample, flush_shift, clear_win;
    logic signed [cconv_pkg::SAMPLE_BITS-1:0] shift_val;
    cconv_pkg::cell_ctrl_t cell_ctrl;
    cconv_pkg::sum_ctrl_t  sum_ctrl;

    logic signed [cconv_pkg::SAMPLE_BITS-1:0] win      [MAX_TAPS];
    logic signed [cconv_pkg::SAMPLE_BITS-1:0] cell_din [MAX_TAPS];
    logic signed [cconv_pkg::COEF_BITS-1:0]   coef_sel [MAX_TAPS];
    logic signed [cconv_pkg::PROD_BITS-1:0]   prod     [MAX_TAPS];
    logic signed [cconv_pkg::SUM_BITS-1:0]    sum;
    logic                                     win_zero;

    // Configuration writes
    assign coef_addr = cfg_index - cconv_pkg::REG_COEF_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= cconv_pkg::TAP_COUNT_RESET;
            for (int i = 0; i < cconv_pkg::COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == cconv_pkg::REG_TAP_COUNT)
            begin
                tap_count_reg <= cfg_data[cconv_pkg::TAP_BITS-1:0];
            end
            else
            begin
                coef_reg[coef_addr] <= cfg_data;
            end
        end
    end

    // Taps in use and look-ahead
    always_comb
    begin
        taps_c = (tap_count_reg > cconv_pkg::TAP_BITS'(TAPS_USED))
               ? cconv_pkg::TAP_BITS'(TAPS_USED) : tap_count_reg;
        look_full = (taps_c == '0) ? '0 : (taps_c - 3'd1 - (taps_c >> 1));
        look      = look_full[CNT_W-1:0];
        seen_eff  = (seen_reg > look) ? look : seen_reg;
        left_dec  = left_reg - CNT_W'(1);
    end

    // Stage advance: a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv_d        = !d_valid_reg || result_ready;
        adv_c        = !c_valid_reg || adv_d;
        adv_b        = !b_valid_reg || adv_c;
        shift_ok     = !a_valid_reg || adv_b;
        sample_ready = shift_ok && !flushing_reg;
        take_sample  = sample_valid && sample_ready;
        flush_shift  = flushing_reg && shift_ok;
        clear_win    = a_valid_reg && a_last_reg && adv_b;
        shift_val    = take_sample ? sample_data.sample : '0;
    end

    // Window stage, count and flush sequencing
    always_comb
    begin
        a_valid_next  = a_valid_reg && !adv_b;
        a_last_next   = a_last_reg;
        seen_next     = seen_reg;
        flushing_next = flushing_reg;
        left_next     = left_reg;
        fseen_next    = fseen_reg;
        if (take_sample)
        begin
            a_valid_next = (seen_eff == look);
            if (sample_data.last_sample)
            begin
                a_last_next   = (look == '0);
                seen_next     = '0;
                flushing_next = (look != '0);
                left_next     = look;
                fseen_next    = seen_eff;
            end
            else
            begin
                a_last_next = 1'b0;
                seen_next   = (seen_eff == look) ? seen_eff : seen_eff + CNT_W'(1);
            end
        end
        else if (flush_shift)
        begin
            // zero shifts before the pending results stay silent
            a_valid_next  = (left_dec <= fseen_reg);
            a_last_next   = (left_dec == '0);
            left_next     = left_dec;
            flushing_next = (left_dec != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            flushing_reg <= 1'b0;
            left_reg     <= '0;
            fseen_reg    <= '0;
            a_valid_reg  <= 1'b0;
            a_last_reg   <= 1'b0;
        end
        else
        begin
            seen_reg     <= seen_next;
            flushing_reg <= flushing_next;
            left_reg     <= left_next;
            fseen_reg    <= fseen_next;
            a_valid_reg  <= a_valid_next;
            a_last_reg   <= a_last_next;
        end
    end

    // Valid and last flags of the product, group and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
            c_valid_reg <= 1'b0;
            c_last_reg  <= 1'b0;
            d_valid_reg <= 1'b0;
            d_last_reg  <= 1'b0;
        end
        else
        begin
            if (adv_b)
            begin
                b_valid_reg <= a_valid_reg;
                b_last_reg  <= a_last_reg;
            end
            if (adv_c)
            begin
                c_valid_reg <= b_valid_reg;
                c_last_reg  <= b_last_reg;
            end
            if (adv_d)
            begin
                d_valid_reg <= c_valid_reg;
                d_last_reg  <= c_last_reg;
            end
        end
    end

    // Cell chain
    always_comb
    begin
        cell_ctrl.shift = take_sample || flush_shift;
        cell_ctrl.clear = clear_win;
        cell_ctrl.load  = a_valid_reg && adv_b;
    end

    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        // neighbor hand-off; a clear drops everything behind the new sample
        if (k == 0)
        begin : g_head
            assign cell_din[k] = shift_val;
        end
        else
        begin : g_body
            assign cell_din[k] = clear_win ? '0 : win[k-1];
        end

        // cell k meets coefficient (taps - 1 - k)
        if (k < TAPS_USED)
        begin : g_coef
            logic [cconv_pkg::TAP_BITS-1:0] coef_idx;
            assign coef_idx    = taps_c - 3'd1 - cconv_pkg::TAP_BITS'(k);
            assign coef_sel[k] = (cconv_pkg::TAP_BITS'(k) < taps_c) ? coef_reg[coef_idx] : '0;
        end
        else
        begin : g_nocoef
            assign coef_sel[k] = '0;
        end

        cconv_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .din      (cell_din[k]),
            .coef     (coef_sel[k]),
            .sample_q (win[k]),
            .prod_q   (prod[k])
        );
    end

    // Adder tree
    always_comb
    begin
        sum_ctrl.load_grp = b_valid_reg && adv_c;
        sum_ctrl.load_out = c_valid_reg && adv_d;
    end

    cconv_adder #(
        .MAX_TAPS (MAX_TAPS)
    ) u_adder
    (
        .clk  (clk),
        .ctrl (sum_ctrl),
        .prod (prod),
        .sum  (sum)
    );

    // Output transaction
    always_comb
    begin
        result_valid            = d_valid_reg;
        result_data.sum         = sum;
        result_data.last_result = d_last_reg;
    end

    // Window emptiness, for checking
    always_comb
    begin
        win_zero = 1'b1;
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            if (win[i] != '0)
            begin
                win_zero = 1'b0;
            end
        end
    end

    // A clear with no new sample leaves an empty window
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear_win && !(take_sample || flush_shift) |=> win_zero)
        else $error("window not cleared after final result");

    // Flush never runs with nothing left to shift
    a_flush_left: assert property (@(posedge clk) disable iff (!rst_n)
        flushing_reg |-> (left_reg != '0))
        else $error("flush active with zero shifts left");

    // The final result of a vector is staged only after the flush ends
    a_final_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && a_last_reg |-> !flushing_reg)
        else $error("final result staged during flush");

    // A sample that does not fill the look-ahead yields no result
    a_warmup_silent: assert property (@(posedge clk) disable iff (!rst_n)
        take_sample && !sample_data.last_sample && (seen_eff != look) |=> !a_valid_reg)
        else $error("result emitted during warm-up");

endmodule

// ===== bench/centered_1d_convolution_tb.sv =====
// Self-checking testbench for centered_1d_convolution: a directed table, then random
// vectors under several idle and stall patterns, checked against a built-in predictor.
// Depends on cconv_pkg and the centered_1d_convolution RTL.
`timescale 1ns / 1ps

module centered_1d_convolution_tb;

    localparam int MAX_TAPS   = 7;
    localparam int SETTLE_CYC = 12;    // output pipeline plus longest flush
    localparam int HOLD_CYC   = 80;    // long receiver hold-off
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 50;

    typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

    typedef struct {
        row_kind_t                                 kind;
        logic [cconv_pkg::CFG_INDEX_BITS-1:0]      index;
        logic [cconv_pkg::CFG_DATA_BITS-1:0]       value;
        cconv_pkg::sample_item_t                   it;
        bit                                        typed;
        cconv_pkg::result_item_t                   want;
    } dir_row_t;

    logic                                    clk          = 1'b0;
    logic                                    rst_n        = 1'b0;
    logic                                    sample_valid = 1'b0;
    logic                                    sample_ready;
    cconv_pkg::sample_item_t                 sample_data  = '0;
    logic                                    result_valid;
    logic                                    result_ready = 1'b0;
    cconv_pkg::result_item_t                 result_data;
    logic                                    cfg_we       = 1'b0;
    logic [cconv_pkg::CFG_INDEX_BITS-1:0]    cfg_index    = '0;
    logic [cconv_pkg::CFG_DATA_BITS-1:0]     cfg_data     = '0;

    // Predictor state: mirrored registers, window (index 0 newest), count
    logic [cconv_pkg::TAP_BITS-1:0]          taps_cfg;
    longint                                  coef_val [cconv_pkg::COEF_REGS];
    longint                                  sample_window [MAX_TAPS];
    int unsigned                             seen_cnt;
    cconv_pkg::result_item_t                 conv_out [4];

    cconv_pkg::result_item_t                 pending_results [$];
    dir_row_t                                dir_rows [$];
    int                                      mismatch_count = 0;

    // Idle controls
    int                          send_idle_pct = 0;
    int                          stall_pct     = 0;
    logic                        pressure_on   = 1'b0;
    logic                        hold_taken    = 1'b0;
    int                          hold_left     = 0;

    centered_1d_convolution DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void shift_window(input longint v);
        for (int k = MAX_TAPS - 1; k > 0; k--)
        begin
            sample_window[k] = sample_window[k - 1];
        end
        sample_window[0] = v;
    endfunction

    // Oldest sample in the window meets coef_0
    function automatic logic signed [cconv_pkg::SUM_BITS-1:0] window_sum(input int unsigned c);
        longint acc;
        acc = 0;
        for (int unsigned j = 0; j < c; j++)
        begin
            acc += sample_window[c - 1 - j] * coef_val[j];
        end
        return acc[cconv_pkg::SUM_BITS-1:0];
    endfunction

    // Fills conv_out with the results one sample causes; returns how many
    function automatic int predict_conv(input cconv_pkg::sample_item_t it);
        int unsigned c;
        int unsigned look;
        int unsigned seen;
        int          n;
        c    = (taps_cfg > MAX_TAPS) ? MAX_TAPS : taps_cfg;
        look = (c == 0) ? 0 : c - 1 - c / 2;
        seen = (seen_cnt > look) ? look : seen_cnt;
        n    = 0;
        shift_window(longint'(it.sample));
        if (!it.last_sample)
        begin
            if (seen >= look)
            begin
                conv_out[0].sum         = window_sum(c);
                conv_out[0].last_result = 1'b0;
                n = 1;
            end
            else
            begin
                seen++;
            end
            seen_cnt = seen;
            return n;
        end
        // End of vector: pad with zeros and flush everything pending
        for (int unsigned k = seen; k < look; k++)
        begin
            shift_window(0);
        end
        for (int unsigned k = 0; k <= seen; k++)
        begin
            if (k > 0)
            begin
                shift_window(0);
            end
            conv_out[n].sum         = window_sum(c);
            conv_out[n].last_result = (k == seen);
            n++;
        end
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            sample_window[k] = 0;
        end
        seen_cnt = 0;
        return n;
    endfunction

    function automatic void queue_expected(input cconv_pkg::sample_item_t it);
        int n;
        n = predict_conv(it);
        for (int k = 0; k < n; k++)
        begin
            pending_results.push_back(conv_out[k]);
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // Leaves valid high after the transaction; the next call may lower it, a drain lowers it
    task automatic send_sample(input cconv_pkg::sample_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= it;
        @(posedge clk);
        while (!sample_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Leaves the write enable high; the caller lowers it after the batch
    task automatic write_reg(input logic [cconv_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [cconv_pkg::CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == cconv_pkg::REG_TAP_COUNT)
        begin
            taps_cfg = val[cconv_pkg::TAP_BITS-1:0];
        end
        else
        begin
            coef_val[idx - cconv_pkg::REG_COEF_FIRST] = longint'($signed(val));
        end
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------- directed table

    function automatic void push_row(input row_kind_t kind,
                                     input logic [cconv_pkg::CFG_INDEX_BITS-1:0] idx,
                                     input logic [cconv_pkg::CFG_DATA_BITS-1:0] val,
                                     input logic [15:0] s, input logic last,
                                     input bit typed,
                                     input logic signed [cconv_pkg::SUM_BITS-1:0] sum,
                                     input logic last_res);
        dir_row_t r;
        r.kind              = kind;
        r.index             = idx;
        r.value             = val;
        r.it.sample         = s;
        r.it.last_sample    = last;
        r.typed             = typed;
        r.want.sum          = sum;
        r.want.last_result  = last_res;
        dir_rows.push_back(r);
    endfunction

    function automatic void push_write(input logic [cconv_pkg::CFG_INDEX_BITS-1:0] idx,
                                       input logic [cconv_pkg::CFG_DATA_BITS-1:0] val);
        push_row(ROW_WRITE, idx, val, 16'h0000, 1'b0, 1'b0, '0, 1'b0);
    endfunction

    function automatic void push_sample(input logic [15:0] s, input logic last);
        push_row(ROW_SAMPLE, '0, '0, s, last, 1'b0, '0, 1'b0);
    endfunction

    // Row whose single result is known outright
    function automatic void push_typed(input logic [15:0] s, input logic last,
                                       input logic signed [cconv_pkg::SUM_BITS-1:0] sum,
                                       input logic last_res);
        push_row(ROW_SAMPLE, '0, '0, s, last, 1'b1, sum, last_res);
    endfunction

    // ---------------------------------------------------------------- receiver

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (pressure_on && !hold_taken)
        begin
            hold_left    <= HOLD_CYC;
            hold_taken   <= 1'b1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= stall_pct);
        end
        if (!pressure_on)
        begin
            hold_taken <= 1'b0;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual sum=%0d last_result=%0b",
                         $time, $signed(result_data.sum), result_data.last_result);
            end
            else
            begin
                cconv_pkg::result_item_t want;
                want = pending_results.pop_front();
                if (result_data.sum !== want.sum)
                begin
                    mismatch_count++;
                    $display("%0t: sum: expected %0d, actual %0d", $time,
                             $signed(want.sum), $signed(result_data.sum));
                end
                if (result_data.last_result !== want.last_result)
                begin
                    mismatch_count++;
                    $display("%0t: last_result: expected %0b, actual %0b", $time,
                             want.last_result, result_data.last_result);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial
    begin
        bit                      writing;
        int                      vec_left;
        cconv_pkg::sample_item_t it;

        taps_cfg = cconv_pkg::TAP_COUNT_RESET;
        seen_cnt = 0;
        for (int k = 0; k < cconv_pkg::COEF_REGS; k++)
        begin
            coef_val[k] = 0;
        end
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            sample_window[k] = 0;
        end

        // Reset defaults: five taps, all coefficients zero
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_typed(16'h0001, 1'b0, 35'sd0, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        // One tap, most negative coefficient against both sample extremes
        push_write(cconv_pkg::REG_TAP_COUNT, 16'd1);
        push_write(cconv_pkg::REG_COEF_FIRST, 16'h8000);
        push_typed(16'h8000, 1'b0, 35'sd1073741824, 1'b0);
        push_typed(16'h7FFF, 1'b1, -35'sd1073709056, 1'b1);
        // Full mask of extremes; the last sample flushes the deepest look-ahead
        push_write(cconv_pkg::REG_TAP_COUNT, 16'd7);
        for (int k = 1; k < cconv_pkg::COEF_REGS; k++)
        begin
            push_write(cconv_pkg::CFG_INDEX_BITS'(cconv_pkg::REG_COEF_FIRST + k),
                       (k % 2) ? 16'h7FFF : 16'h8000);
        end
        push_sample(16'h8000, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b1);
        // Zero taps, upper data bits set: every sum is zero
        push_write(cconv_pkg::REG_TAP_COUNT, 16'hFFF8);
        push_typed(16'h0005, 1'b0, 35'sd0, 1'b0);
        push_typed(16'hFFFB, 1'b1, 35'sd0, 1'b1);
        // Two taps: no look-ahead
        push_write(cconv_pkg::REG_TAP_COUNT, 16'd2);
        push_sample(16'd100, 1'b0);
        push_sample(16'd200, 1'b1);
        // Vector of a single sample
        push_write(cconv_pkg::REG_TAP_COUNT, 16'd4);
        push_sample(16'h1234, 1'b1);
        // Tap count lowered in the middle of a vector
        push_write(cconv_pkg::REG_TAP_COUNT, 16'd7);
        push_sample(16'h0101, 1'b0);
        push_sample(16'hFEFE, 1'b0);
        push_sample(16'h4000, 1'b0);
        push_write(cconv_pkg::REG_TAP_COUNT, 16'd3);
        push_sample(16'hC000, 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        writing = 1'b0;
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_WRITE)
            begin
                if (!writing)
                begin
                    wait_drained();
                end
                writing = 1'b1;
                write_reg(dir_rows[r].index, dir_rows[r].value);
            end
            else
            begin
                if (writing)
                begin
                    cfg_we <= 1'b0;
                end
                writing = 1'b0;
                send_sample(dir_rows[r].it);
                if (dir_rows[r].typed)
                begin
                    void'(predict_conv(dir_rows[r].it));
                    pending_results.push_back(dir_rows[r].want);
                end
                else
                begin
                    queue_expected(dir_rows[r].it);
                end
            end
        end

        // Random vectors; a vector may run across a phase boundary
        vec_left = 0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            pressure_on <= 1'b0;
            case (phase % 5)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 52; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 52; end
                3:       begin send_idle_pct = 17; stall_pct = 17; end
                default: begin send_idle_pct = 0;  stall_pct = 0;  end
            endcase
            if (phase == 0)
            begin
                write_reg(cconv_pkg::REG_TAP_COUNT, {13'($urandom), 3'd7});
            end
            else if (phase == 1)
            begin
                write_reg(cconv_pkg::REG_TAP_COUNT, {13'($urandom), 3'd1});
            end
            else
            begin
                write_reg(cconv_pkg::REG_TAP_COUNT, 16'($urandom));
            end
            for (int k = 0; k < cconv_pkg::COEF_REGS; k++)
            begin
                write_reg(cconv_pkg::CFG_INDEX_BITS'(cconv_pkg::REG_COEF_FIRST + k),
                          rand_word());
            end
            cfg_we <= 1'b0;
            if (phase % 5 == 4)
            begin
                pressure_on <= 1'b1;
            end

            for (int i = 0; i < PHASE_LEN; i++)
            begin
                if (vec_left == 0)
                begin
                    vec_left = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 8);
                end
                it.sample      = rand_word();
                it.last_sample = (vec_left == 1);
                vec_left--;
                send_sample(it);
                queue_expected(it);
            end
        end

        wait_drained();
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cconv_pkg.sv
rtl/core/cconv_cell.sv
rtl/core/cconv_adder.sv
rtl/core/centered_1d_convolution.sv
bench/centered_1d_convolution_tb.sv
